[rtl/core/afpms_pkg.sv]
package afpms_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned TIME_W = 31;

   // register indexes on the control port
   localparam logic [2:0] REG_MASS      = 3'd0;
   localparam logic [2:0] REG_DAMPING   = 3'd1;
   localparam logic [2:0] REG_STIFFNESS = 3'd2;
   localparam logic [2:0] REG_FORCE_T0  = 3'd3;
   localparam logic [2:0] REG_CONST_MODE = 3'd4;
   localparam logic [2:0] REG_PLATE_ACC = 3'd5;
   localparam logic [2:0] REG_IMPACT_T  = 3'd6;

   localparam logic signed [31:0] MASS_RESET = 32'sd65536;

   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
   localparam logic signed [63:0] Q_LIM  = 64'sd70368744177664;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_HH,
      ST_MUL_HD,
      ST_HB,
      ST_DIV_AVG,
      ST_MUL_HK,
      ST_C1,
      ST_MUL_C1,
      ST_MUL_C2,
      ST_NUM,
      ST_DIV_NEXT,
      ST_DIV_VEL,
      ST_DIV_Q,
      ST_DIV_ACC,
      ST_MUL_VT,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) r = 32'sh7fffffff;
      else if (v < SAT_LO) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // halve, rounding toward zero
   function automatic logic signed [63:0] half_tz(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + {63'd0, v[63]};
      return t >>> 1;
   endfunction

endpackage

[rtl/core/afpms_req_if.sv]
interface afpms_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] force_sample;
   logic [30:0]        sim_time;
   logic [30:0]        step_size;

   modport source (output valid, force_sample, sim_time, step_size, input ready);
   modport sink (input valid, force_sample, sim_time, step_size, output ready);
endinterface

[rtl/core/afpms_rsp_if.sv]
interface afpms_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] average_force;
   logic signed [31:0] position;
   logic signed [31:0] velocity;
   logic signed [31:0] acceleration;
   logic               step_error;

   modport source (output valid, average_force, position, velocity, acceleration,
                   step_error, input ready);
   modport sink (input valid, average_force, position, velocity, acceleration,
                 step_error, output ready);
endinterface

[rtl/core/afpms_div.sv]
module afpms_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic signed [63:0] divisor,
   output logic               done,
   output logic signed [63:0] quotient
);
   import afpms_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [64:0] trial;

   // one quotient bit a cycle, magnitudes only, sign fixed at the end
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff[63:0], quo_ff[63]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = dividend[63] ^ divisor[63];
         quo_in  = dividend[63] ? 64'(-dividend) : 64'(dividend);
         dvs_in  = divisor[63] ? 64'(-divisor) : 64'(divisor);
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

[rtl/core/averaged_force_plate_motion_step_top.sv]
// averaged force plate motion step
// req channel: one beat carries a force sample, the simulation time and the
// step size, all Q16.16. rsp channel: one beat per request with the window
// average, new position, velocity, acceleration and a step error flag.
// csr port: APB-style, seven registers at byte address 4*i, always ready,
// reads return the stored value; the user must see that they are written
// only while the block is idle, as the block itself does not enforce it.
// each request is worked by a sequencer around one 33x33 multiplier and one
// 64-step restoring divider; the divider runs five times (window average,
// new position, velocity, two stages of acceleration). a zero step or zero
// denominator ends after the window average. req.ready is high only while
// idle, one request at a time: a new request is taken only once the rsp
// beat of the last one has gone. the rsp beat is held in registers until
// taken; a stalled receiver keeps the block busy and req.ready low until
// the beat goes.
// reset (synchronous) clears the window, the running sum, both plate
// positions and the registers to their defaults.
module averaged_force_plate_motion_step_top #(
   parameter int unsigned WINDOW_LEN = 8
) (
   input  logic        clock,
   input  logic        reset,
   afpms_req_if.sink   req,
   afpms_rsp_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import afpms_pkg::*;

   localparam int unsigned SUM_W = 33 + $clog2(WINDOW_LEN);

   // control registers
   logic signed [31:0] mass_ff, damp_ff, stiff_ff, pacc_ff;
   logic [30:0]        fst_ff, impact_ff;
   logic               mode_ff;
   logic [2:0]         csr_idx;

   // plate state and window
   logic signed [31:0]      win_ff [WINDOW_LEN];
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [31:0]      prior_ff, prior_in, pres_ff, pres_in;

   // working registers
   state_type          state_ff, state_in;
   logic [30:0]        h_ff, h_in, t_ff, t_in;
   logic signed [31:0] avg_ff, avg_in, h2_ff, h2_in, c1_ff, c1_in, c2_ff, c2_in;
   logic signed [31:0] next_ff, next_in, vel_ff, vel_in, accel_ff, accel_in;
   logic signed [63:0] hb_ff, hb_in, den_ff, den_in, accum_ff, accum_in;
   logic               err_ff, err_in;
   logic signed [65:0] prod_ff, prod_in;

   // shared multiplier operands and product scaled back to Q16.16
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_rnd;
   logic signed [63:0] mq;

   // divider hookup
   logic               div_start, div_done;
   logic signed [63:0] div_num, div_den, div_q;

   logic               req_beat, rsp_beat;
   logic signed [31:0] drive, sat_q;
   logic signed [63:0] h_s, tau_s, qc, diff;

   assign req_beat = req.valid && req.ready;
   assign rsp_beat = rsp.valid && rsp.ready;
   assign csr_idx  = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   // control port
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff   <= MASS_RESET;
         damp_ff   <= '0;
         stiff_ff  <= '0;
         fst_ff    <= '0;
         mode_ff   <= 1'b0;
         pacc_ff   <= '0;
         impact_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            REG_MASS:       mass_ff   <= csr_pwdata;
            REG_DAMPING:    damp_ff   <= csr_pwdata;
            REG_STIFFNESS:  stiff_ff  <= csr_pwdata;
            REG_FORCE_T0:   fst_ff    <= csr_pwdata[30:0];
            REG_CONST_MODE: mode_ff   <= csr_pwdata[0];
            REG_PLATE_ACC:  pacc_ff   <= csr_pwdata;
            REG_IMPACT_T:   impact_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MASS:       csr_prdata = mass_ff;
         REG_DAMPING:    csr_prdata = damp_ff;
         REG_STIFFNESS:  csr_prdata = stiff_ff;
         REG_FORCE_T0:   csr_prdata = {1'b0, fst_ff};
         REG_CONST_MODE: csr_prdata = {31'd0, mode_ff};
         REG_PLATE_ACC:  csr_prdata = pacc_ff;
         REG_IMPACT_T:   csr_prdata = {1'b0, impact_ff};
         default:        csr_prdata = '0;
      endcase
   end

   afpms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // product truncated toward zero, then dropped 16 fraction bits
   assign prod_rnd = prod_ff[65] ? prod_ff + 66'sd65535 : prod_ff;
   assign mq       = 64'(prod_rnd >>> 16);
   assign prod_in  = mul_a * mul_b;

   assign h_s   = $signed({33'd0, h_ff});
   assign tau_s = $signed({33'd0, t_ff - impact_ff});
   assign drive = (t_ff < fst_ff) ? 32'sd0 : avg_ff;
   assign sat_q = sat32(div_q);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      sum_in    = sum_ff;
      prior_in  = prior_ff;
      pres_in   = pres_ff;
      h_in      = h_ff;
      t_in      = t_ff;
      avg_in    = avg_ff;
      h2_in     = h2_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      next_in   = next_ff;
      vel_in    = vel_ff;
      accel_in  = accel_ff;
      hb_in     = hb_ff;
      den_in    = den_ff;
      accum_in  = accum_ff;
      err_in    = err_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = h_s;
      qc        = '0;
      diff      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               h_in     = req.step_size;
               t_in     = req.sim_time;
               sum_in   = sum_ff + SUM_W'(req.force_sample) - SUM_W'(win_ff[0]);
               state_in = ST_MUL_HH;
            end
         end
         ST_MUL_HH: begin
            mul_a    = $signed({2'b00, h_ff});
            mul_b    = $signed({2'b00, h_ff});
            state_in = ST_MUL_HD;
         end
         ST_MUL_HD: begin
            h2_in    = sat32(mq);
            mul_a    = $signed({2'b00, h_ff});
            mul_b    = 33'(damp_ff);
            state_in = ST_HB;
         end
         ST_HB: begin
            hb_in     = half_tz(mq);
            den_in    = 64'(mass_ff) + half_tz(mq);
            err_in    = (h_ff == '0) || (64'(mass_ff) + half_tz(mq) == 64'sd0);
            div_start = 1'b1;
            div_num   = 64'(sum_ff);
            div_den   = 64'(WINDOW_LEN);
            state_in  = ST_DIV_AVG;
         end
         ST_DIV_AVG: begin
            if (div_done) begin
               avg_in = div_q[31:0];
               if (err_ff) begin
                  vel_in   = '0;
                  accel_in = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MUL_HK;
               end
            end
         end
         ST_MUL_HK: begin
            mul_a    = 33'(h2_ff);
            mul_b    = 33'(stiff_ff);
            state_in = ST_C1;
         end
         ST_C1: begin
            c1_in    = sat32((64'(mass_ff) <<< 1) - mq);
            c2_in    = sat32(64'(mass_ff) - hb_ff);
            mul_a    = 33'(h2_ff);
            mul_b    = 33'(drive);
            state_in = ST_MUL_C1;
         end
         ST_MUL_C1: begin
            accum_in = mq;
            mul_a    = 33'(c1_ff);
            mul_b    = 33'(pres_ff);
            state_in = ST_MUL_C2;
         end
         ST_MUL_C2: begin
            accum_in = accum_ff + mq;
            mul_a    = 33'(c2_ff);
            mul_b    = 33'(prior_ff);
            state_in = ST_NUM;
         end
         ST_NUM: begin
            div_start = 1'b1;
            div_num   = 64'(sat32(accum_ff - mq)) <<< 16;
            div_den   = den_ff;
            state_in  = ST_DIV_NEXT;
         end
         ST_DIV_NEXT: begin
            if (div_done) begin
               next_in   = sat_q;
               div_start = 1'b1;
               div_num   = (64'(sat_q) - 64'(prior_ff)) <<< 15;
               state_in  = ST_DIV_VEL;
            end
         end
         ST_DIV_VEL: begin
            if (div_done) begin
               vel_in    = sat_q;
               diff      = 64'(next_ff) - (64'(pres_ff) <<< 1) + 64'(prior_ff);
               div_start = 1'b1;
               div_num   = diff <<< 16;
               state_in  = ST_DIV_Q;
            end
         end
         ST_DIV_Q: begin
            if (div_done) begin
               if (div_q > Q_LIM) qc = Q_LIM;
               else if (div_q < -Q_LIM) qc = -Q_LIM;
               else qc = div_q;
               div_start = 1'b1;
               div_num   = qc <<< 16;
               state_in  = ST_DIV_ACC;
            end
         end
         ST_DIV_ACC: begin
            if (div_done) begin
               accel_in = sat_q;
               prior_in = pres_ff;
               pres_in  = next_ff;
               // no position pending unless the kinematics path marks it
               accum_in = '0;
               state_in = ST_OUT;
               if (mode_ff) begin
                  if (t_ff < impact_ff) begin
                     accel_in = '0;
                     vel_in   = '0;
                     pres_in  = '0;
                  end else begin
                     // constant acceleration kinematics from impact time
                     accel_in = pacc_ff;
                     mul_a    = 33'(pacc_ff);
                     mul_b    = 33'(tau_s);
                     state_in = ST_MUL_VT;
                  end
               end
            end
         end
         ST_MUL_VT: begin
            vel_in   = sat32(mq);
            mul_a    = 33'(sat32(mq));
            mul_b    = 33'(tau_s);
            // position follows in the next cycle, taken in the output state
            state_in = ST_OUT;
            err_in   = 1'b0;
            accum_in = 64'sd1;
         end
         ST_OUT: begin
            if (accum_ff == 64'sd1 && !err_ff && mode_ff) begin
               pres_in  = sat32(half_tz(mq));
               accum_in = '0;
            end else if (rsp_beat) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sum_ff   <= '0;
         prior_ff <= '0;
         pres_ff  <= '0;
         accum_ff <= '0;
         err_ff   <= 1'b0;
         for (int i = 0; i < WINDOW_LEN; i++) win_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         prior_ff <= prior_in;
         pres_ff  <= pres_in;
         accum_ff <= accum_in;
         err_ff   <= err_in;
         if (req_beat) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) win_ff[i] <= win_ff[i + 1];
            win_ff[WINDOW_LEN - 1] <= req.force_sample;
         end
      end
      h_ff     <= h_in;
      t_ff     <= t_in;
      avg_ff   <= avg_in;
      h2_ff    <= h2_in;
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      next_ff  <= next_in;
      vel_ff   <= vel_in;
      accel_ff <= accel_in;
      hb_ff    <= hb_in;
      den_ff   <= den_in;
      prod_ff  <= prod_in;
   end

   // the rsp beat waits while the constant-mode position settles
   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = (state_ff == ST_OUT) && !(accum_ff == 64'sd1 && !err_ff && mode_ff);
   assign rsp.average_force = avg_ff;
   assign rsp.position      = pres_ff;
   assign rsp.velocity      = vel_ff;
   assign rsp.acceleration  = accel_ff;
   assign rsp.step_error    = err_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req.ready)
      else $error("request accepted while busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("ready and response valid together");

   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.step_error) |-> (rsp.velocity == 0 && rsp.acceleration == 0))
      else $error("error beat carries motion");

endmodule

[sim/afpms_motion_checker.sv]
module afpms_motion_checker (
   input  logic clock,
   input  logic reset,
   afpms_req_if req,
   afpms_rsp_if rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import afpms_pkg::*;

   typedef struct {
      logic signed [31:0] average_force;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
      logic               step_error;
   } plate_step_type;

   plate_step_type plate_steps_due[$];

   // shadow of the registers and the plate state
   longint mass, damping, stiffness, accel_set;
   longint force_t0, impact_t;
   bit     const_mode;
   longint window_q[8];
   longint pos_prior, pos_now;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) / 65536;
   endfunction

   function automatic plate_step_type advance_plate(longint force_in, longint t, longint h);
      plate_step_type r;
      longint sum, avg, drive, h2, hb, den, c1, c2, num, nxt, vel, acc, q, tau;
      sum = 0;
      for (int i = 0; i < 7; i++) window_q[i] = window_q[i+1];
      window_q[7] = force_in;
      for (int i = 0; i < 8; i++) sum += window_q[i];
      avg   = sum / 8;
      drive = (t < force_t0) ? 0 : avg;
      h2    = clamp32(qmul(h, h));
      hb    = qmul(h, damping) / 2;
      den   = mass + hb;
      r.average_force = avg[31:0];
      if (h == 0 || den == 0) begin
         r.position     = pos_now[31:0];
         r.velocity     = '0;
         r.acceleration = '0;
         r.step_error   = 1'b1;
         return r;
      end
      c1  = clamp32(2 * mass - qmul(h2, stiffness));
      c2  = clamp32(mass - hb);
      num = clamp32(qmul(h2, drive) + qmul(c1, pos_now) - qmul(c2, pos_prior));
      nxt = clamp32((num * 65536) / den);
      vel = clamp32(((nxt - pos_prior) * 32768) / h);
      q   = ((nxt - 2 * pos_now + pos_prior) * 65536) / h;
      if (q > 64'sd70368744177664) q = 64'sd70368744177664;
      if (q < -64'sd70368744177664) q = -64'sd70368744177664;
      acc = clamp32((q * 65536) / h);
      pos_prior = pos_now;
      pos_now   = nxt;
      if (const_mode) begin
         if (t < impact_t) begin
            acc = 0;
            vel = 0;
            pos_now = 0;
         end else begin
            tau = t - impact_t;
            acc = accel_set;
            vel = clamp32(qmul(acc, tau));
            pos_now = clamp32(qmul(vel, tau) / 2);
         end
      end
      r.position     = pos_now[31:0];
      r.velocity     = vel[31:0];
      r.acceleration = acc[31:0];
      r.step_error   = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      plate_step_type due;
      if (reset) begin
         mass = 65536; damping = 0; stiffness = 0; accel_set = 0;
         force_t0 = 0; impact_t = 0; const_mode = 0;
         for (int i = 0; i < 8; i++) window_q[i] = 0;
         pos_prior = 0; pos_now = 0;
         plate_steps_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_MASS:       mass       = longint'($signed(csr_pwdata));
               REG_DAMPING:    damping    = longint'($signed(csr_pwdata));
               REG_STIFFNESS:  stiffness  = longint'($signed(csr_pwdata));
               REG_FORCE_T0:   force_t0   = longint'(csr_pwdata[30:0]);
               REG_CONST_MODE: const_mode = csr_pwdata[0];
               REG_PLATE_ACC:  accel_set  = longint'($signed(csr_pwdata));
               REG_IMPACT_T:   impact_t   = longint'(csr_pwdata[30:0]);
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (plate_steps_due.size() == 0) begin
               $error("unexpected rsp beat");
               fail_count++;
            end else begin
               due = plate_steps_due.pop_front();
               if (rsp.average_force !== due.average_force) begin
                  $error("average_force exp %0d got %0d", due.average_force, rsp.average_force);
                  fail_count++;
               end
               if (rsp.position !== due.position) begin
                  $error("position exp %0d got %0d", due.position, rsp.position);
                  fail_count++;
               end
               if (rsp.velocity !== due.velocity) begin
                  $error("velocity exp %0d got %0d", due.velocity, rsp.velocity);
                  fail_count++;
               end
               if (rsp.acceleration !== due.acceleration) begin
                  $error("acceleration exp %0d got %0d", due.acceleration, rsp.acceleration);
                  fail_count++;
               end
               if (rsp.step_error !== due.step_error) begin
                  $error("step_error exp %0b got %0b", due.step_error, rsp.step_error);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready)
            plate_steps_due.push_back(advance_plate(longint'(req.force_sample),
               longint'(req.sim_time), longint'(req.step_size)));
      end
   end

   initial fail_count = 0;

   // called by the top at the end of the run
   function automatic int steps_left();
      return plate_steps_due.size();
   endfunction
endmodule

[sim/averaged_force_plate_motion_step_top_tb.sv]
module averaged_force_plate_motion_step_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import afpms_pkg::*;

   logic clock;
   logic reset;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int          fail_count;

   afpms_req_if req ();
   afpms_rsp_if rsp ();

   averaged_force_plate_motion_step_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   afpms_motion_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count)
   );

   // idling controls for the sender and receiver processes, and run counters
   int  gap_pct;
   int  stall_pct;
   bit  hold_req;
   int  beats_sent;
   int  beats_taken;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // count taken rsp beats and watch for a hung block
   always @(posedge clock) begin
      if (reset) begin
         beats_taken  <= 0;
         quiet_cycles <= 0;
      end else begin
         if (rsp.valid && rsp.ready) beats_taken <= beats_taken + 1;
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp.ready <= 1'b0;
            // long stretch so the block backs up and drops req.ready
            repeat (3000) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one request beat, with random sender idling ahead of it
   task automatic send_step(input logic [31:0] f, input logic [30:0] t, input logic [30:0] h);
      while ($urandom_range(99) < gap_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.force_sample <= f;
      req.sim_time     <= t;
      req.step_size    <= h;
      do @(posedge clock); while (!(req.valid && req.ready));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (beats_taken < beats_sent) @(posedge clock);
      // nothing more in flight; a short pause before touching registers
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'd0;
         3: return 32'd65536;
         4: return $urandom;
         default: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
      endcase
   endfunction

   function automatic logic [30:0] pick_time();
      case ($urandom_range(3))
         0: return 31'h7fffffff;
         1: return 31'd0;
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, 32'h000fffff));
      endcase
   endfunction

   task automatic random_step();
      logic [31:0] f;
      logic [30:0] t, h;
      int r;
      r = $urandom_range(99);
      f = (r < 50) ? ($urandom_range(0, 32'h7ffff) - 32'h3ffff) : $urandom;
      t = 31'(($urandom_range(1)) ? $urandom : $urandom_range(0, 32'h001fffff));
      r = $urandom_range(99);
      if (r < 5)       h = '0;
      else if (r < 15) h = 31'($urandom);
      else             h = 31'($urandom_range(1, 32'h00020000));
      send_step(f, t, h);
   endtask

   initial begin
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.force_sample = '0;
      req.sim_time     = '0;
      req.step_size    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      gap_pct     = 0;
      stall_pct   = 0;
      hold_req    = 1'b0;
      beats_sent  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: defaults, extremes of each field, zero step
      send_step(32'h7fffffff, 31'd0, 31'd65536);
      send_step(32'h80000000, 31'h7fffffff, 31'h7fffffff);
      send_step(32'h00010000, 31'd100, 31'd0);
      send_step(32'hffff0000, 31'd200, 31'd1);
      send_step(32'h12345678, 31'h55555555, 31'h2aaaaaaa);
      send_step(32'hedcba987, 31'h2aaaaaaa, 31'h55555555);
      drain();
      // force held off before the start time, then let through
      csr_write(REG_FORCE_T0, 32'h00050000);
      csr_write(REG_DAMPING, 32'h00008000);
      csr_write(REG_STIFFNESS, 32'h00004000);
      send_step(32'h00100000, 31'h00040000, 31'd4096);
      send_step(32'h00100000, 31'h00050000, 31'd4096);
      send_step(32'h00100000, 31'h00060000, 31'd4096);
      drain();
      // zero denominator: mass zero with no damping
      csr_write(REG_MASS, 32'd0);
      csr_write(REG_DAMPING, 32'd0);
      send_step(32'h00020000, 31'd10, 31'd65536);
      drain();
      // constant acceleration before and after impact
      csr_write(REG_MASS, 32'd65536);
      csr_write(REG_CONST_MODE, 32'd1);
      csr_write(REG_PLATE_ACC, 32'hfff00000);
      csr_write(REG_IMPACT_T, 32'h00030000);
      send_step(32'h00010000, 31'h00020000, 31'd8192);
      send_step(32'h00010000, 31'h00030000, 31'd8192);
      send_step(32'h00010000, 31'h00048000, 31'd8192);
      send_step(32'h00010000, 31'h7fffffff, 31'd8192);
      drain();
      csr_write(REG_PLATE_ACC, 32'h7fffffff);
      send_step(32'h00010000, 31'h7fffffff, 31'd8192);
      drain();

      // random phases, each with fresh registers and an idling pattern
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_MASS, ($urandom_range(2) == 0) ? pick_coef() : 32'd65536);
         csr_write(REG_DAMPING, pick_coef());
         csr_write(REG_STIFFNESS, pick_coef());
         csr_write(REG_FORCE_T0, {1'b0, pick_time()});
         csr_write(REG_CONST_MODE, {31'd0, ph[0]});
         csr_write(REG_PLATE_ACC, pick_coef());
         csr_write(REG_IMPACT_T, {1'b0, pick_time()});
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 73; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 73; end
            default: begin gap_pct = 15; stall_pct = 15; end
         endcase
         if (ph == 2) hold_req = 1'b1;
         repeat (228) random_step();
         drain();
      end

      repeat (400) @(posedge clock);
      if (fail_count == 0 && checker_i.steps_left() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
